// ===== rtl/core/sgrs_pkg.sv =====
// Package for the SGR escape stripper: byte constants, word and command types.
// No dependencies; every module of the block imports it.
package sgrs_pkg;

    // Longest held sequence before it is given up and released.
    localparam int MaxSeqLen = 63;
    // Entries in the held-byte store and its address width.
    localparam int HeldDepth = 64;
    localparam int AddrW     = $clog2(HeldDepth);
    // Width of the held-byte count, which never rests above MaxSeqLen.
    localparam int CntW      = $clog2(MaxSeqLen + 1);
    // Command queue between the front and the back.
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);

    // Byte codes that steer the classifier.
    localparam logic [7:0] EscByte  = 8'h1B;
    localparam logic [7:0] CsiOpen  = 8'h5B;
    localparam logic [7:0] SgrFinal = 8'h6D;
    localparam logic [7:0] FinalLo  = 8'h40;
    localparam logic [7:0] FinalHi  = 8'h7E;
    localparam logic [7:0] ParamLo  = 8'h20;
    localparam logic [7:0] ParamHi  = 8'h3F;

    // Input word and result word.
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_word_t;

    // Commands from the front to the back.
    typedef enum logic [1:0] {
        OP_PASS    = 2'd0,
        OP_HOLD    = 2'd1,
        OP_RELEASE = 2'd2
    } cmd_op_t;

    // PASS emits data; HOLD stores data at entry cnt; RELEASE replays cnt
    // stored bytes and, when tail is set, then emits data as the last byte.
    typedef struct packed {
        cmd_op_t         op;
        logic            tail;
        logic [7:0]      data;
        logic [CntW-1:0] cnt;
    } cmd_t;

    // Status seen by the top-level checks.
    typedef struct packed {
        logic plain;
        logic cnt_zero;
    } fe_status_t;

    typedef struct packed {
        logic replaying;
        logic cnt_zero;
    } be_status_t;

endpackage

// ===== rtl/core/sgrs_front.sv =====
// Front of the SGR escape stripper: accepts input words, tracks the escape
// phase and held count, and turns each word into back-end commands. Uses sgrs_pkg.
module sgrs_front
    import sgrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    output logic       push,
    output cmd_t       push_cmd,
    input  logic       fifo_full,
    output fe_status_t status
);

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_ESC   = 3'b010,
        PH_CSI   = 3'b100
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            accept;
    logic [CntW:0]   cnt_inc;
    logic [7:0]      b;
    logic            is_final;
    logic            is_param;

    // A word is taken whenever the queue has room for its command.
    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign cnt_inc = {1'b0, cnt_reg} + (CntW+1)'(1);

    assign is_final = (b >= FinalLo) && (b <= FinalHi);
    assign is_param = (b >= ParamLo) && (b <= ParamHi);

    // Classify the word and decide which command, if any, goes to the back.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        push_cmd   = '{op: OP_PASS, tail: 1'b0, data: b, cnt: cnt_reg};
        if (accept) begin
            if (s_data.mode) begin
                // Flush releases whatever is held; nothing held gives no result.
                push          = (cnt_reg != '0);
                push_cmd.op   = OP_RELEASE;
                cnt_next      = '0;
                phase_next    = PH_PLAIN;
            end else begin
                case (phase_reg)
                    PH_ESC: begin
                        if (b == CsiOpen) begin
                            push        = 1'b1;
                            push_cmd.op = OP_HOLD;
                            cnt_next    = cnt_inc[CntW-1:0];
                            phase_next  = PH_CSI;
                        end else begin
                            push          = 1'b1;
                            push_cmd.op   = OP_RELEASE;
                            push_cmd.tail = 1'b1;
                            cnt_next      = '0;
                            phase_next    = PH_PLAIN;
                        end
                    end
                    PH_CSI: begin
                        if (is_final && (b == SgrFinal)) begin
                            // A color sequence is dropped without output.
                            cnt_next   = '0;
                            phase_next = PH_PLAIN;
                        end else if (is_final || !is_param ||
                                     (cnt_inc > (CntW+1)'(MaxSeqLen))) begin
                            push          = 1'b1;
                            push_cmd.op   = OP_RELEASE;
                            push_cmd.tail = 1'b1;
                            cnt_next      = '0;
                            phase_next    = PH_PLAIN;
                        end else begin
                            push        = 1'b1;
                            push_cmd.op = OP_HOLD;
                            cnt_next    = cnt_inc[CntW-1:0];
                        end
                    end
                    default: begin
                        // Plain text, and any stray phase code, behaves as plain.
                        phase_next = PH_PLAIN;
                        push       = 1'b1;
                        if (b == EscByte) begin
                            push_cmd.op  = OP_HOLD;
                            push_cmd.cnt = '0;
                            cnt_next     = CntW'(1);
                            phase_next   = PH_ESC;
                        end else begin
                            push_cmd.op = OP_PASS;
                        end
                    end
                endcase
            end
        end
    end

    // Phase and count registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PLAIN;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign status.plain    = (phase_reg == PH_PLAIN);
    assign status.cnt_zero = (cnt_reg == '0);

endmodule

// ===== rtl/core/sgrs_cmd_fifo.sv =====
// Short command queue between the front and the back of the SGR escape stripper.
// Uses the command type from sgrs_pkg.
module sgrs_cmd_fifo
    import sgrs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t                entries [FifoDepth];
    logic [FifoPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FifoPtrW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (FifoPtrW+1)'(FifoDepth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries[rd_ptr_reg];

    // Storage for queued commands.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FifoPtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FifoPtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (FifoPtrW+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (FifoPtrW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/core/sgrs_back.sv =====
// Back of the SGR escape stripper: owns the held-byte store, carries out the
// queued commands and drives the result register. Uses sgrs_pkg.
module sgrs_back
    import sgrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data,
    output be_status_t status
);

    typedef enum logic [2:0] {
        B_IDLE   = 3'b001,
        B_REPLAY = 3'b010,
        B_TAIL   = 3'b100
    } back_state_t;

    back_state_t     state_reg, state_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [7:0]      held_mem [HeldDepth];
    logic            m_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            last_reg;
    logic            load_ok;
    logic            load;
    logic            load_mem;
    logic            load_last;
    logic            mem_we;
    logic            final_idx;

    // The result register can take a new word when empty or being drained.
    assign load_ok   = !m_valid_reg || m_ready;
    assign final_idx = (idx_reg == (head.cnt - CntW'(1)));

    // Command sequencer.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        load       = 1'b0;
        load_mem   = 1'b0;
        load_last  = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    case (head.op)
                        OP_HOLD: begin
                            mem_we = 1'b1;
                            pop    = 1'b1;
                        end
                        OP_PASS: begin
                            if (load_ok) begin
                                load      = 1'b1;
                                load_last = 1'b1;
                                pop       = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            idx_next = '0;
                            if (head.cnt != '0) begin
                                state_next = B_REPLAY;
                            end else if (head.tail) begin
                                state_next = B_TAIL;
                            end else begin
                                pop = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            B_REPLAY: begin
                // One stored byte per cycle while the result side keeps up.
                if (load_ok) begin
                    load      = 1'b1;
                    load_mem  = 1'b1;
                    load_last = final_idx && !head.tail;
                    idx_next  = idx_reg + CntW'(1);
                    if (final_idx) begin
                        if (head.tail) begin
                            state_next = B_TAIL;
                        end else begin
                            pop        = 1'b1;
                            state_next = B_IDLE;
                        end
                    end
                end
            end
            B_TAIL: begin
                // The byte that ended the sequence goes out last.
                if (load_ok) begin
                    load       = 1'b1;
                    load_last  = 1'b1;
                    pop        = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Held-byte store write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            held_mem[AddrW'(head.cnt)] <= head.data;
        end
    end

    // Result payload: registered store read or the command's own byte.
    always_ff @(posedge aclk) begin
        if (load) begin
            if (load_mem) begin
                out_byte_reg <= held_mem[AddrW'(idx_reg)];
            end else begin
                out_byte_reg <= head.data;
            end
            last_reg <= load_last;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_data.out_byte  = out_byte_reg;
    assign m_data.last      = last_reg;
    assign status.replaying = (state_reg == B_REPLAY);
    assign status.cnt_zero  = (head.cnt == '0);

endmodule

// ===== rtl/core/ansi_sgr_escape_stripper.sv =====
// Top level of the SGR escape stripper: front classifier, command queue, back.
// Depends on sgrs_pkg, sgrs_front, sgrs_cmd_fifo and sgrs_back.
//
//   Channel   Ports                       Word
//   input     s_valid, s_ready, s_data    in_word_t  {mode, data_byte}
//   result    m_valid, m_ready, m_data    out_word_t {out_byte, last}
//
// The front takes one input word per cycle while the four-entry command queue
// has room. The back stores each held byte and hands on each passed byte. A
// release first starts a replay, then reads out the stored bytes in order and
// last the byte that ended the sequence; a flush reads out only the stored
// bytes. The held-byte store's single read port sets one byte per cycle. A
// stalled result register holds the back, and a full queue holds the input.
// Reset is synchronous and active low; the store needs no clearing.
module ansi_sgr_escape_stripper
    import sgrs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    cmd_t       head;
    logic       fifo_full;
    logic       fifo_empty;
    fe_status_t fe_status;
    be_status_t be_status;

    // Classifier.
    sgrs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .fifo_full (fifo_full),
        .status    (fe_status)
    );

    // Command queue.
    sgrs_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // Executor and result register.
    sgrs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (fifo_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .status  (be_status)
    );

`ifndef NO_ASSERTIONS
    // Outside any sequence the front holds no bytes.
    a_plain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        fe_status.plain |-> fe_status.cnt_zero)
        else $error("held count nonzero in plain phase");

    // A replay always has stored bytes to read.
    a_replay_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        be_status.replaying |-> !be_status.cnt_zero)
        else $error("replay started with an empty release");

    // No result word is presented right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule
